// ===== rtl/crcfr_pkg.sv =====
// Shared types, constants and the CRC update function of the frame receiver.
// Used by every module and by the channel interfaces; depends on nothing.

package crcfr_pkg;

    localparam logic [7:0] CRC_POLY          = 8'h91;
    localparam logic [7:0] START_BYTE_RESET  = 8'd50;
    localparam logic [3:0] MAX_RESENDS_RESET = 4'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RESENDS = 1'b1;

    // Input mode codes.
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    // Result kind codes.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RESEND     = 2'd1;
    localparam logic [1:0] STATUS_LIMIT      = 2'd2;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd3;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_TYPE  = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_CRC   = 6'b010000,
        PH_TRAIL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] frame_length;
        logic [1:0] status;
        logic       resend_request;
        logic [3:0] error_count;
    } res_item_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [3:0] max_resends;
    } cfg_t;

    // Reflected CRC-8 step: XOR the byte in, then eight shift/XOR rounds.
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[0])
            begin
                v = v ^ CRC_POLY;
            end
            v = v >> 1;
        end
        return v;
    endfunction

endpackage

// ===== rtl/crcfr_if.sv =====
// Valid/ready channel interfaces of the frame receiver: received bytes,
// results and configuration writes. Depends on crcfr_pkg.

interface crcfr_rx_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface crcfr_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       resend_request;
    logic [3:0] error_count;

    modport source (output valid, kind, data, frame_length, status, resend_request,
                    error_count, input ready);
    modport sink   (input valid, kind, data, frame_length, status, resend_request,
                    error_count, output ready);
endinterface

interface crcfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [crcfr_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                       wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/crcfr_cfg_regs.sv =====
// Configuration registers: start byte and resend limit.
// Depends on crcfr_pkg and crcfr_cfg_if.

module crcfr_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    crcfr_cfg_if.sink         cfg,
    output crcfr_pkg::cfg_t   cfg_out
);

    logic [7:0] start_byte_reg;
    logic [3:0] max_resends_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= crcfr_pkg::START_BYTE_RESET;
            max_resends_reg <= crcfr_pkg::MAX_RESENDS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                crcfr_pkg::REG_START_BYTE:  start_byte_reg  <= cfg.wdata;
                crcfr_pkg::REG_MAX_RESENDS: max_resends_reg <= cfg.wdata[3:0];
                default: ;
            endcase
        end
    end

    assign cfg_out.start_byte  = start_byte_reg;
    assign cfg_out.max_resends = max_resends_reg;

endmodule

// ===== rtl/crcfr_deframer.sv =====
// Input register and deframing state machine with the CRC check.
// Depends on crcfr_pkg and crcfr_rx_if.

module crcfr_deframer (
    input  logic                  clk,
    input  logic                  rst_n,
    crcfr_rx_if.sink              rx,
    input  crcfr_pkg::cfg_t       cfg_in,
    input  logic                  out_free,
    output logic                  res_load,
    output crcfr_pkg::res_item_t  res_item
);

    logic                  hold_valid_reg;
    crcfr_pkg::rx_item_t   hold_item_reg;
    logic                  advance;

    crcfr_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]            crc_reg, crc_next;
    logic [7:0]            type_reg, type_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            left_reg, left_next;
    logic [3:0]            err_run_reg, err_run_next;

    logic [7:0]            b;
    logic [7:0]            crc_upd;
    logic                  produce;

    // The held request moves on whenever the result register has room.
    assign advance  = hold_valid_reg && out_free;
    assign rx.ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            hold_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            hold_item_reg.mode    <= rx.mode;
            hold_item_reg.rx_byte <= rx.rx_byte;
        end
    end

    assign b       = hold_item_reg.rx_byte;
    assign crc_upd = crcfr_pkg::crc_update(crc_reg, b);

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        err_run_next = err_run_reg;
        produce      = 1'b0;
        res_item     = '0;

        if (hold_item_reg.mode == crcfr_pkg::MODE_TIMEOUT)
        begin
            phase_next = crcfr_pkg::PH_HUNT;
            if (phase_reg == crcfr_pkg::PH_TYPE || phase_reg == crcfr_pkg::PH_LEN ||
                phase_reg == crcfr_pkg::PH_DATA || phase_reg == crcfr_pkg::PH_CRC)
            begin
                produce                 = 1'b1;
                res_item.kind           = crcfr_pkg::KIND_VERDICT;
                res_item.data           = type_reg;
                res_item.frame_length   = len_reg;
                res_item.status         = crcfr_pkg::STATUS_INCOMPLETE;
                res_item.error_count    = err_run_reg;
            end
        end
        else
        begin
            unique case (phase_reg)
                crcfr_pkg::PH_HUNT:
                begin
                    if (b == cfg_in.start_byte)
                    begin
                        crc_next   = '0;
                        type_next  = '0;
                        len_next   = '0;
                        left_next  = '0;
                        phase_next = crcfr_pkg::PH_TYPE;
                    end
                end
                crcfr_pkg::PH_TYPE:
                begin
                    type_next  = b;
                    crc_next   = crc_upd;
                    phase_next = crcfr_pkg::PH_LEN;
                end
                crcfr_pkg::PH_LEN:
                begin
                    len_next   = b;
                    left_next  = b;
                    crc_next   = crc_upd;
                    phase_next = (b == 8'd0) ? crcfr_pkg::PH_CRC : crcfr_pkg::PH_DATA;
                end
                crcfr_pkg::PH_DATA:
                begin
                    crc_next      = crc_upd;
                    left_next     = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = crcfr_pkg::PH_CRC;
                    end
                    produce       = 1'b1;
                    res_item.kind = crcfr_pkg::KIND_PAYLOAD;
                    res_item.data = b;
                end
                crcfr_pkg::PH_CRC:
                begin
                    produce               = 1'b1;
                    res_item.kind         = crcfr_pkg::KIND_VERDICT;
                    res_item.data         = type_reg;
                    res_item.frame_length = len_reg;
                    if (b == crc_reg)
                    begin
                        err_run_next    = '0;
                        res_item.status = crcfr_pkg::STATUS_OK;
                    end
                    else if (err_run_reg < cfg_in.max_resends)
                    begin
                        err_run_next            = err_run_reg + 4'd1;
                        res_item.status         = crcfr_pkg::STATUS_RESEND;
                        res_item.resend_request = 1'b1;
                    end
                    else
                    begin
                        res_item.status = crcfr_pkg::STATUS_LIMIT;
                    end
                    res_item.error_count = err_run_next;
                    phase_next           = crcfr_pkg::PH_TRAIL;
                end
                crcfr_pkg::PH_TRAIL:
                begin
                    phase_next = crcfr_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = crcfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    assign res_load = advance && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= crcfr_pkg::PH_HUNT;
            crc_reg     <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            err_run_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            err_run_reg <= err_run_next;
        end
    end

endmodule

// ===== rtl/crcfr_out_reg.sv =====
// Result register driving the result channel.
// Depends on crcfr_pkg and crcfr_res_if.

module crcfr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  crcfr_pkg::res_item_t  item,
    output logic                  free,
    crcfr_res_if.source           res
);

    logic                  valid_reg;
    crcfr_pkg::res_item_t  item_reg;

    // Room when empty, or when the held result is taken in this cycle.
    assign free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign res.valid          = valid_reg;
    assign res.kind           = item_reg.kind;
    assign res.data           = item_reg.data;
    assign res.frame_length   = item_reg.frame_length;
    assign res.status         = item_reg.status;
    assign res.resend_request = item_reg.resend_request;
    assign res.error_count    = item_reg.error_count;

endmodule

// ===== rtl/crc_checked_frame_receiver_core.sv =====
// Top level of the CRC-checked frame receiver.
// Depends on crcfr_pkg, crcfr_if, crcfr_cfg_regs, crcfr_deframer and crcfr_out_reg.
//
//   channel  direction  fields                                        accepted when
//   rx       in         mode, rx_byte                                 rx.valid && rx.ready
//   res      out        kind, data, frame_length, status,             res.valid && res.ready
//                       resend_request, error_count
//   cfg      in         index, wdata                                  cfg.valid (ready always high)
//
// One request per cycle unless res stalls: a byte enters the input register, the
// state machine and the unrolled CRC step act on it from there, and any result
// lands in the output register, which drives the res channel.
// Reset restores the register defaults and sends the deframer hunting for a start byte.
// A stall on res holds the input register only while the output register is full.

module crc_checked_frame_receiver_core (
    input  logic          clk,
    input  logic          rst_n,
    crcfr_rx_if.sink      rx,
    crcfr_res_if.source   res,
    crcfr_cfg_if.sink     cfg
);

    crcfr_pkg::cfg_t       cfg_val;
    crcfr_pkg::res_item_t  res_item;
    logic                  res_load;
    logic                  out_free;

    crcfr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    crcfr_deframer u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg_in   (cfg_val),
        .out_free (out_free),
        .res_load (res_load),
        .res_item (res_item)
    );

    crcfr_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .item  (res_item),
        .free  (out_free),
        .res   (res)
    );

endmodule

// ===== sim/crcfr_checker.sv =====
// Checker for the CRC-checked frame receiver: watches the received-byte, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on crcfr_pkg and the channel interfaces in crcfr_if.

module crcfr_checker (
    input  logic   clk,
    input  logic   rst_n,
    crcfr_rx_if    rx,
    crcfr_res_if   res,
    crcfr_cfg_if   cfg,
    output int     fail_count,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    cfg_t       settings;
    phase_t     phase;
    logic [7:0] crc_acc;
    logic [7:0] msg_type;
    logic [7:0] msg_len;
    logic [7:0] remaining;
    logic [3:0] err_run;

    res_item_t  expected_out[$];

    // One byte of the reflected CRC: shifting out a set bit folds in 0x91 >> 1.
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        logic       lsb;
        v = acc ^ b;
        repeat (8)
        begin
            lsb = v[0];
            v = {1'b0, v[7:1]} ^ (lsb ? 8'h48 : 8'h00);
        end
        return v;
    endfunction

    task automatic deframe_step(input logic m, input logic [7:0] b);
        res_item_t r;
        r = '0;
        if (m == MODE_TIMEOUT)
        begin
            // A timeout with a frame in progress closes it as incomplete.
            if (phase != PH_HUNT && phase != PH_TRAIL)
            begin
                r.kind         = KIND_VERDICT;
                r.data         = msg_type;
                r.frame_length = msg_len;
                r.status       = STATUS_INCOMPLETE;
                r.error_count  = err_run;
                expected_out.push_back(r);
            end
            phase = PH_HUNT;
        end
        else
        begin
            case (phase)
                PH_TYPE:
                begin
                    msg_type = b;
                    crc_acc  = crc8_fold(crc_acc, b);
                    phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    msg_len   = b;
                    remaining = b;
                    crc_acc   = crc8_fold(crc_acc, b);
                    phase     = (b == 8'd0) ? PH_CRC : PH_DATA;
                end
                PH_DATA:
                begin
                    crc_acc   = crc8_fold(crc_acc, b);
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                    begin
                        phase = PH_CRC;
                    end
                    r.kind = KIND_PAYLOAD;
                    r.data = b;
                    expected_out.push_back(r);
                end
                PH_CRC:
                begin
                    r.kind         = KIND_VERDICT;
                    r.data         = msg_type;
                    r.frame_length = msg_len;
                    if (b == crc_acc)
                    begin
                        err_run  = 4'd0;
                        r.status = STATUS_OK;
                    end
                    else if (err_run < settings.max_resends)
                    begin
                        err_run          = err_run + 4'd1;
                        r.status         = STATUS_RESEND;
                        r.resend_request = 1'b1;
                    end
                    else
                    begin
                        r.status = STATUS_LIMIT;
                    end
                    r.error_count = err_run;
                    phase = PH_TRAIL;
                    expected_out.push_back(r);
                end
                PH_TRAIL:
                begin
                    phase = PH_HUNT;
                end
                default:
                begin
                    if (b == settings.start_byte)
                    begin
                        crc_acc   = 8'd0;
                        msg_type  = 8'd0;
                        msg_len   = 8'd0;
                        remaining = 8'd0;
                        phase     = PH_TYPE;
                    end
                    else
                    begin
                        phase = PH_HUNT;
                    end
                end
            endcase
        end
    endtask

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        fail_count++;
    endtask

    task automatic check_result();
        res_item_t want;
        res_item_t got;
        got = '{kind: res.kind, data: res.data, frame_length: res.frame_length,
                status: res.status, resend_request: res.resend_request,
                error_count: res.error_count};
        if (expected_out.size() == 0)
        begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            fail_count++;
        end
        else
        begin
            want = expected_out.pop_front();
            if (got.kind !== want.kind)
                report_field("kind", 8'(want.kind), 8'(got.kind));
            if (got.data !== want.data)
                report_field("data", want.data, got.data);
            if (got.frame_length !== want.frame_length)
                report_field("frame_length", want.frame_length, got.frame_length);
            if (got.status !== want.status)
                report_field("status", 8'(want.status), 8'(got.status));
            if (got.resend_request !== want.resend_request)
                report_field("resend_request", 8'(want.resend_request),
                             8'(got.resend_request));
            if (got.error_count !== want.error_count)
                report_field("error_count", 8'(want.error_count), 8'(got.error_count));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.start_byte  = START_BYTE_RESET;
            settings.max_resends = MAX_RESENDS_RESET;
            phase       = PH_HUNT;
            crc_acc     = 8'd0;
            msg_type    = 8'd0;
            msg_len     = 8'd0;
            remaining   = 8'd0;
            err_run     = 4'd0;
            expected_out.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                case (cfg.index)
                    REG_START_BYTE:  settings.start_byte  = cfg.wdata;
                    REG_MAX_RESENDS: settings.max_resends = cfg.wdata[3:0];
                    default: ;
                endcase
            end
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                deframe_step(rx.mode, rx.rx_byte);
            end
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                check_result();
            end
            outstanding = expected_out.size();
        end
    end

endmodule

// ===== sim/crc_checked_frame_receiver_core_test.sv =====
// Top of the frame receiver testbench: clock, reset, directed and random frames,
// configuration phases and the verdict. Depends on crcfr_pkg, crcfr_if, the block
// crc_checked_frame_receiver_core and the checker crcfr_checker.

module crc_checked_frame_receiver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int ITEMS_PER_PHASE = 85;

    logic       clk;
    logic       rst_n;
    bit         no_idle;
    int         items_sent;
    int         cycle_count = 0;
    int         fail_count;
    int         outstanding;
    logic [7:0] cur_start;

    crcfr_rx_if  rx_ch ();
    crcfr_res_if res_ch ();
    crcfr_cfg_if cfg_ch ();

    crc_checked_frame_receiver_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    crcfr_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("crc_checked_frame_receiver_core verification failed");
            $finish;
        end
    end

    // The result side stalls in bursts until the last phase.
    initial
    begin
        res_ch.ready <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!no_idle && $urandom_range(0, 1) == 1)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic m, input logic [7:0] b, input bit counted);
        rx_ch.valid   <= 1'b1;
        rx_ch.mode    <= m;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (rx_ch.ready !== 1'b1);
        if (counted)
        begin
            items_sent++;
        end
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Sends start, type, length, payload, CRC and trailer. When cut_at indexes a
    // byte after the start byte, a timeout request replaces it and ends the frame.
    task automatic send_frame(input logic [7:0] ftype, input int flen, input bit good_crc,
                              input int cut_at);
        logic [7:0] body[$];
        logic [7:0] acc;
        body.push_back(ftype);
        body.push_back(flen[7:0]);
        repeat (flen) body.push_back(8'($urandom));
        acc = 8'h00;
        foreach (body[i]) acc = crc_update(acc, body[i]);
        if (!good_crc)
        begin
            acc ^= 8'($urandom_range(1, 255));
        end
        body.push_back(acc);
        body.push_back(($urandom_range(0, 7) == 0) ? cur_start : 8'($urandom));
        send_item(MODE_BYTE, cur_start, 1'b1);
        for (int i = 0; i < body.size(); i++)
        begin
            if (i == cut_at)
            begin
                send_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
                return;
            end
            send_item(MODE_BYTE, body[i], 1'b1);
        end
    endtask

    task automatic rand_frame(input int bad_pct);
        int sel;
        int flen;
        sel  = $urandom_range(0, 99);
        flen = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
        if (sel < 70)
        begin
            send_frame(8'($urandom), flen, $urandom_range(1, 100) > bad_pct, -1);
        end
        else if (sel < 85)
        begin
            send_frame(8'($urandom), flen, $urandom_range(0, 1) == 1,
                       $urandom_range(0, flen + 3));
        end
        else
        begin
            // Line noise: stray bytes and timeouts, not counted.
            repeat ($urandom_range(1, 4))
                send_item(($urandom_range(0, 3) == 0) ? MODE_TIMEOUT : MODE_BYTE,
                          8'($urandom), 1'b0);
        end
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] dcrc;
        logic [7:0] ph_start;
        logic [3:0] ph_max;
        int         bad_pct;
        int         phase_goal;

        rx_ch.valid   <= 1'b0;
        rx_ch.mode    <= MODE_BYTE;
        rx_ch.rx_byte <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_START_BYTE;
        cfg_ch.wdata  <= 8'h00;
        no_idle    = 1'b0;
        items_sent = 0;
        cur_start  = START_BYTE_RESET;
        @(posedge rst_n);
        @(posedge clk);

        // Directed part at the reset settings.
        send_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
        send_frame(8'hFF, 0, 1'b1, -1);
        // Start byte value inside the payload, a bad CRC, then a timeout on the trailer.
        dcrc = crc_update(crc_update(crc_update(crc_update(8'h00, 8'h00), 8'h02),
                          cur_start), 8'hFF) ^ 8'h01;
        send_item(MODE_BYTE, cur_start, 1'b1);
        send_item(MODE_BYTE, 8'h00, 1'b1);
        send_item(MODE_BYTE, 8'h02, 1'b1);
        send_item(MODE_BYTE, cur_start, 1'b1);
        send_item(MODE_BYTE, 8'hFF, 1'b1);
        send_item(MODE_BYTE, dcrc, 1'b1);
        send_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
        send_frame(8'hA5, 3, 1'b1, 3);
        send_frame(8'h7E, 1, 1'b1, 1);
        send_frame(8'h00, 0, 1'b1, 0);
        send_frame(8'h3C, 0, 1'b1, 2);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    ph_start = START_BYTE_RESET;
                    ph_max   = MAX_RESENDS_RESET;
                    bad_pct  = 30;
                end
                1:
                begin
                    ph_start = 8'h00;
                    ph_max   = 4'd0;
                    bad_pct  = 50;
                end
                2:
                begin
                    ph_start = 8'hFF;
                    ph_max   = 4'd15;
                    bad_pct  = 100;
                end
                3:
                begin
                    // The error run left by the previous phase exceeds this limit.
                    ph_start = 8'hA5;
                    ph_max   = 4'd3;
                    bad_pct  = 40;
                end
                4:
                begin
                    ph_start = 8'($urandom);
                    ph_max   = 4'($urandom_range(0, 15));
                    bad_pct  = 50;
                end
                default:
                begin
                    ph_start = START_BYTE_RESET;
                    ph_max   = MAX_RESENDS_RESET;
                    bad_pct  = 30;
                end
            endcase
            wait_idle();
            write_reg(REG_START_BYTE, ph_start);
            write_reg(REG_MAX_RESENDS, {4'h0, ph_max});
            cur_start = ph_start;
            if (p == 5)
            begin
                no_idle = 1'b1;
            end
            phase_goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_goal) rand_frame(bad_pct);
            if (p == 2)
            begin
                send_frame(8'($urandom), 255, 1'b0, -1);
            end
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("crc_checked_frame_receiver_core verification clean");
        end
        else
        begin
            $display("crc_checked_frame_receiver_core verification failed");
        end
        $finish;
    end

endmodule
